[rtl/ssl_pkg.sv]
// Package: shared types, constants and codes of the start/stop latency monitor.
package ssl_pkg;

  // Default parameter values
  localparam int FRACTION_BITS_DEF = 8;
  localparam int COUNTER_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int TS_W       = 64;
  localparam int EVNO_W     = 12;
  localparam int LAT_W      = 48;
  localparam int MEAN_W     = 56;
  localparam int SDEV_W     = 55;
  localparam int CNT_OUT_W  = 32;
  localparam int SUM_W      = 64;
  localparam int ROOT_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int QUEUE_DEPTH = 2;

  // Event decoding
  localparam logic [3:0]        FMT_TIMING   = 4'h1;
  localparam logic [EVNO_W-1:0] EVNO_EXCL_LO = 12'h0e0;
  localparam logic [EVNO_W-1:0] EVNO_EXCL_HI = 12'h0e4;
  localparam logic [9:0]        US_TO_NS     = 10'd1000;
  localparam logic [2:0]        MODE_NO_TIME = 3'd3;
  localparam logic [2:0]        MODE_NO_EVNO = 3'd4;
  localparam logic [1:0]        KIND_START   = 2'd0;
  localparam logic [1:0]        KIND_STOP    = 2'd1;
  localparam logic              CMD_CLEAR    = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_OFFSET  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 2'd3;

  // Counter slots
  localparam logic [2:0] CNT_START    = 3'd0;
  localparam logic [2:0] CNT_STOP     = 3'd1;
  localparam logic [2:0] CNT_MATCH    = 3'd2;
  localparam logic [2:0] CNT_NOSTART  = 3'd3;
  localparam logic [2:0] CNT_MISMATCH = 3'd4;
  localparam logic [2:0] CNT_ORDER    = 3'd5;
  localparam int         NUM_CNT      = 6;

  // Saturation bounds
  localparam logic signed [LAT_W-1:0]  LAT_MAX_V  = {1'b0, {(LAT_W-1){1'b1}}};
  localparam logic signed [LAT_W-1:0]  LAT_MIN_V  = {1'b1, {(LAT_W-1){1'b0}}};
  localparam logic signed [MEAN_W-1:0] MEAN_MAX_V = {1'b0, {(MEAN_W-1){1'b1}}};
  localparam logic signed [MEAN_W-1:0] MEAN_MIN_V = {1'b1, {(MEAN_W-1){1'b0}}};
  localparam logic signed [TS_W-1:0]   CLAMP_V    = 64'sh4000000000000000;
  localparam logic [TS_W-1:0]          ROOT_BIT0  = 64'h4000000000000000;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_SKIP,
    OP_START,
    OP_STOP
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [EVNO_W-1:0]   evno;
    logic [TS_W-1:0]     deadline;
  } op_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [15:0]        window;
    logic [31:0]        stop_off;
    logic signed [31:0] start_off;
  } cfg_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_EXEC,
    B_LAT,
    B_STAT,
    B_DIV_MEAN,
    B_MEAN,
    B_MUL,
    B_SUM,
    B_DIV_VAR,
    B_SQRT,
    B_OUT
  } back_state_t;

endpackage

[rtl/ssl_channels.sv]
// Interfaces: input event channel and result channel.
interface ssl_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [63:0] event_id;
  logic [63:0] deadline_ns;
  logic [1:0]  event_kind;

  modport source (output valid, cmd, event_id, deadline_ns, event_kind, input ready);
  modport sink   (input valid, cmd, event_id, deadline_ns, event_kind, output ready);
endinterface

interface ssl_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        starts_seen;
  logic [31:0]        stops_seen;
  logic [31:0]        matches_res;
  logic [31:0]        fail_no_start;
  logic [31:0]        fail_event_mismatch;
  logic [31:0]        fail_order;
  logic signed [47:0] latency_now;
  logic               latency_now_valid;
  logic signed [47:0] latency_min;
  logic signed [47:0] latency_max;
  logic signed [55:0] latency_mean;
  logic [54:0]        latency_sdev;

  modport source (output valid, starts_seen, stops_seen, matches_res, fail_no_start,
                  fail_event_mismatch, fail_order, latency_now, latency_now_valid,
                  latency_min, latency_max, latency_mean, latency_sdev, input ready);
  modport sink   (input valid, starts_seen, stops_seen, matches_res, fail_no_start,
                  fail_event_mismatch, fail_order, latency_now, latency_now_valid,
                  latency_min, latency_max, latency_mean, latency_sdev, output ready);
endinterface

[rtl/ssl_front.sv]
// Front end: accepts input transactions and classifies them into operations.
module ssl_front import ssl_pkg::*; (
  ssl_in_if.sink     in_ch,
  input  logic [2:0] mode,
  output logic       op_valid,
  input  logic       op_grant,
  output op_t        op
);

  logic [3:0]        fmt;
  logic [EVNO_W-1:0] evno;
  logic              excluded;

  assign fmt      = in_ch.event_id[63:60];
  assign evno     = in_ch.event_id[47:36];
  assign excluded = (mode == MODE_NO_TIME) && (evno >= EVNO_EXCL_LO) && (evno <= EVNO_EXCL_HI);

  // Handshake passes straight to the queue
  assign op_valid    = in_ch.valid;
  assign in_ch.ready = op_grant;

  // Classify the transaction
  always_comb begin
    op.evno     = evno;
    op.deadline = in_ch.deadline_ns;
    if (in_ch.cmd == CMD_CLEAR) begin
      op.kind = OP_CLEAR;
    end else if (fmt != FMT_TIMING || excluded) begin
      op.kind = OP_SKIP;
    end else if (in_ch.event_kind == KIND_START) begin
      op.kind = OP_START;
    end else if (in_ch.event_kind == KIND_STOP) begin
      op.kind = OP_STOP;
    end else begin
      op.kind = OP_SKIP;
    end
  end

endmodule

[rtl/ssl_queue.sv]
// Short FIFO of classified operations between front and back end.
module ssl_queue import ssl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  op_t  push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output op_t  pop_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  op_t              mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/ssl_back.sv]
// Back end: pairing, counters, running statistics with serial divide, multiply, root.
module ssl_back import ssl_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      op_valid,
  output logic      op_grant,
  input  op_t       op_in,
  ssl_out_if.source out_ch
);

  localparam int CW     = COUNTER_WIDTH;
  localparam int D_W    = MEAN_W + 1;
  localparam int ACC_W  = 2 * D_W;
  localparam int STEP_W = $clog2(TS_W);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(TS_W - 1);
  localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(D_W - 1);
  localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_W - 1);
  localparam logic [CW-1:0]     CNT_MAX   = {CW{1'b1}};

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  back_state_t state, state_next;

  // Pairing state and statistics
  logic                      pending;
  logic [TS_W-1:0]           start_time;
  logic [EVNO_W-1:0]         start_evno;
  logic [CW-1:0]             cnt [NUM_CNT];
  logic signed [LAT_W-1:0]   lat_now;
  logic                      lat_valid;
  logic signed [LAT_W-1:0]   lat_min;
  logic signed [LAT_W-1:0]   lat_max;
  logic signed [MEAN_W-1:0]  mean;
  logic [SUM_W-1:0]          sum;
  logic [ROOT_W-1:0]         sdev;

  // Work registers
  op_t                       op;
  logic [TS_W-1:0]           diff;
  logic signed [LAT_W-1:0]   lat;
  logic signed [MEAN_W-1:0]  x;
  logic                      d1_neg;
  logic [D_W-1:0]            a;
  logic [D_W-1:0]            b_sh;
  logic [ACC_W-1:0]          acc;
  logic [CW-1:0]             div_rem;
  logic [TS_W-1:0]           div_dq;
  logic [CW-1:0]             divisor;
  logic [TS_W-1:0]           sq_v;
  logic [TS_W-1:0]           sq_r;
  logic [TS_W-1:0]           sq_bit;
  logic [STEP_W-1:0]         step;

  // Output register
  logic                      out_valid;
  logic [CNT_OUT_W-1:0]      o_cnt [NUM_CNT];
  logic signed [LAT_W-1:0]   o_lat_now;
  logic                      o_lat_valid;
  logic signed [LAT_W-1:0]   o_lat_min;
  logic signed [LAT_W-1:0]   o_lat_max;
  logic signed [MEAN_W-1:0]  o_mean;
  logic [ROOT_W-1:0]         o_sdev;

  logic                      pop;
  logic                      out_free;

  // Datapath helpers
  logic                      mode4;
  logic [25:0]               w_ns;
  logic signed [TS_W-1:0]    neg_w;
  logic                      order_fail;
  logic signed [TS_W-1:0]    sd;
  logic signed [TS_W-1:0]    dc;
  logic signed [TS_W:0]      ds;
  logic signed [TS_W:0]      off;
  logic signed [LAT_W-1:0]   lat_c;
  logic signed [TS_W-1:0]    xw;
  logic signed [MEAN_W-1:0]  x_c;
  logic signed [D_W-1:0]     d1_c;
  logic signed [D_W-1:0]     q_c;
  logic signed [D_W-1:0]     mnew_c;
  logic signed [D_W-1:0]     d2_c;
  logic [CW:0]               div_t;
  logic                      div_ge;
  logic [CW-1:0]             div_rem_next;
  logic [TS_W-1:0]           div_dq_next;
  logic [SUM_W-1:0]          prod_c;
  logic [SUM_W:0]            sum_w;
  logic [SUM_W-1:0]          sum_c;
  logic [TS_W-1:0]           sq_rb;
  logic                      sq_ge;
  logic [TS_W-1:0]           sq_r_next;

  // Arithmetic
  always_comb begin
    mode4      = (cfg.mode == MODE_NO_EVNO);
    w_ns       = 26'(cfg.window) * 26'(US_TO_NS);
    neg_w      = -$signed(TS_W'(w_ns));
    sd         = $signed(diff);
    order_fail = sd < neg_w;
    dc         = (sd > CLAMP_V) ? CLAMP_V : ((sd < -CLAMP_V) ? -CLAMP_V : sd);
    off        = mode4 ? (TS_W+1)'($signed(cfg.start_off)) : '0;
    ds         = (TS_W+1)'(dc) + off;
    lat_c      = (ds > (TS_W+1)'(LAT_MAX_V)) ? LAT_MAX_V :
                 ((ds < (TS_W+1)'(LAT_MIN_V)) ? LAT_MIN_V : LAT_W'(ds));
    xw         = TS_W'(lat) <<< FRACTION_BITS;
    x_c        = (xw > TS_W'(MEAN_MAX_V)) ? MEAN_MAX_V :
                 ((xw < TS_W'(MEAN_MIN_V)) ? MEAN_MIN_V : MEAN_W'(xw));
    d1_c       = D_W'(x_c) - D_W'(mean);
    q_c        = d1_neg ? -$signed(D_W'(div_dq)) : $signed(D_W'(div_dq));
    mnew_c     = D_W'(mean) + q_c;
    d2_c       = D_W'(x) - mnew_c;
    // restoring divide step
    div_t        = {div_rem, div_dq[TS_W-1]};
    div_ge       = div_t >= {1'b0, divisor};
    div_rem_next = div_ge ? CW'(div_t - {1'b0, divisor}) : div_t[CW-1:0];
    div_dq_next  = {div_dq[TS_W-2:0], div_ge};
    // saturating product and sum
    prod_c     = (acc[ACC_W-1:SUM_W] != '0) ? {SUM_W{1'b1}} : acc[SUM_W-1:0];
    sum_w      = {1'b0, sum} + {1'b0, prod_c};
    sum_c      = sum_w[SUM_W] ? {SUM_W{1'b1}} : sum_w[SUM_W-1:0];
    // square root step
    sq_rb      = sq_r + sq_bit;
    sq_ge      = sq_v >= sq_rb;
    sq_r_next  = sq_ge ? ((sq_r >> 1) + sq_bit) : (sq_r >> 1);
  end

  assign out_free = !out_valid || out_ch.ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:     if (op_valid) state_next = B_EXEC;
      B_EXEC: begin
        if (op.kind == OP_STOP && pending &&
            (op.evno == start_evno || mode4)) begin
          state_next = B_LAT;
        end else begin
          state_next = B_OUT;
        end
      end
      B_LAT:      state_next = order_fail ? B_OUT : B_STAT;
      B_STAT:     state_next = (cnt[CNT_MATCH] <= CW'(1)) ? B_OUT : B_DIV_MEAN;
      B_DIV_MEAN: if (step == DIV_LAST) state_next = B_MEAN;
      B_MEAN:     state_next = B_MUL;
      B_MUL:      if (step == MUL_LAST) state_next = B_SUM;
      B_SUM:      state_next = B_DIV_VAR;
      B_DIV_VAR:  if (step == DIV_LAST) state_next = B_SQRT;
      B_SQRT:     if (step == ROOT_LAST) state_next = B_OUT;
      B_OUT:      if (out_free) state_next = B_IDLE;
      default:    state_next = B_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    op_grant = 1'b0;
    pop      = 1'b0;
    unique case (state)
      B_IDLE: begin
        op_grant = 1'b1;
        pop      = op_valid;
      end
      default: begin
        op_grant = 1'b0;
        pop      = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Pairing and statistics datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= 1'b0;
      start_time <= '0;
      start_evno <= '0;
      cnt        <= '{default: '0};
      lat_now    <= '0;
      lat_valid  <= 1'b0;
      lat_min    <= LAT_MAX_V;
      lat_max    <= LAT_MIN_V;
      mean       <= '0;
      sum        <= '0;
      sdev       <= '0;
      step       <= '0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (pop) op <= op_in;
        end
        B_EXEC: begin
          unique case (op.kind)
            OP_CLEAR: begin
              cnt       <= '{default: '0};
              lat_now   <= '0;
              lat_valid <= 1'b0;
              lat_min   <= LAT_MAX_V;
              lat_max   <= LAT_MIN_V;
              mean      <= '0;
              sum       <= '0;
              sdev      <= '0;
            end
            OP_START: begin
              cnt[CNT_START] <= sat_inc(cnt[CNT_START]);
              pending        <= 1'b1;
              start_time     <= op.deadline;
              start_evno     <= op.evno;
              lat_valid      <= 1'b0;
            end
            OP_STOP: begin
              cnt[CNT_STOP] <= sat_inc(cnt[CNT_STOP]);
              if (!pending) begin
                cnt[CNT_NOSTART] <= sat_inc(cnt[CNT_NOSTART]);
              end else if (op.evno != start_evno && !mode4) begin
                cnt[CNT_MISMATCH] <= sat_inc(cnt[CNT_MISMATCH]);
              end else begin
                pending <= 1'b0;
                diff    <= op.deadline - TS_W'(cfg.stop_off) - start_time;
              end
            end
            default: begin
            end
          endcase
        end
        B_LAT: begin
          if (order_fail) begin
            cnt[CNT_ORDER] <= sat_inc(cnt[CNT_ORDER]);
          end else begin
            cnt[CNT_MATCH] <= sat_inc(cnt[CNT_MATCH]);
            lat            <= lat_c;
            lat_now        <= lat_c;
            lat_valid      <= 1'b1;
          end
        end
        B_STAT: begin
          if (lat < lat_min) lat_min <= lat;
          if (lat > lat_max) lat_max <= lat;
          x <= x_c;
          if (cnt[CNT_MATCH] <= CW'(1)) begin
            mean <= x_c;
            sum  <= '0;
            sdev <= '0;
          end else begin
            d1_neg  <= d1_c[D_W-1];
            a       <= d1_c[D_W-1] ? D_W'(-d1_c) : D_W'(d1_c);
            div_dq  <= TS_W'(d1_c[D_W-1] ? D_W'(-d1_c) : D_W'(d1_c));
            div_rem <= '0;
            divisor <= cnt[CNT_MATCH];
            step    <= '0;
          end
        end
        B_DIV_MEAN: begin
          div_rem <= div_rem_next;
          div_dq  <= div_dq_next;
          step    <= step + 1'b1;
        end
        B_MEAN: begin
          mean <= MEAN_W'(mnew_c);
          b_sh <= d2_c[D_W-1] ? D_W'(-d2_c) : D_W'(d2_c);
          acc  <= '0;
          step <= '0;
        end
        B_MUL: begin
          acc  <= (acc << 1) + (b_sh[D_W-1] ? ACC_W'(a) : '0);
          b_sh <= b_sh << 1;
          step <= step + 1'b1;
        end
        B_SUM: begin
          sum     <= sum_c;
          div_dq  <= sum_c;
          div_rem <= '0;
          divisor <= cnt[CNT_MATCH] - 1'b1;
          step    <= '0;
        end
        B_DIV_VAR: begin
          div_rem <= div_rem_next;
          div_dq  <= div_dq_next;
          step    <= (step == DIV_LAST) ? '0 : step + 1'b1;
          if (step == DIV_LAST) begin
            sq_v   <= div_dq_next;
            sq_r   <= '0;
            sq_bit <= ROOT_BIT0;
          end
        end
        B_SQRT: begin
          if (sq_ge) sq_v <= sq_v - sq_rb;
          sq_r   <= sq_r_next;
          sq_bit <= sq_bit >> 2;
          step   <= step + 1'b1;
          if (step == ROOT_LAST) sdev <= sq_r_next[ROOT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Result register, loaded with a snapshot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == B_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_OUT && out_free) begin
      for (int i = 0; i < NUM_CNT; i++) begin
        o_cnt[i] <= CNT_OUT_W'(cnt[i]);
      end
      o_lat_now   <= lat_now;
      o_lat_valid <= lat_valid;
      o_lat_min   <= lat_min;
      o_lat_max   <= lat_max;
      o_mean      <= mean;
      o_sdev      <= sdev;
    end
  end

  assign out_ch.valid               = out_valid;
  assign out_ch.starts_seen         = o_cnt[CNT_START];
  assign out_ch.stops_seen          = o_cnt[CNT_STOP];
  assign out_ch.matches_res         = o_cnt[CNT_MATCH];
  assign out_ch.fail_no_start       = o_cnt[CNT_NOSTART];
  assign out_ch.fail_event_mismatch = o_cnt[CNT_MISMATCH];
  assign out_ch.fail_order          = o_cnt[CNT_ORDER];
  assign out_ch.latency_now         = o_lat_now;
  assign out_ch.latency_now_valid   = o_lat_valid;
  assign out_ch.latency_min         = o_lat_min;
  assign out_ch.latency_max         = o_lat_max;
  assign out_ch.latency_mean        = o_mean;
  assign out_ch.latency_sdev        = SDEV_W'(o_sdev);

`ifndef SYNTHESIS
  // A valid latest latency implies at least one match
  a_valid_has_match: assert property (@(posedge clk) disable iff (rst)
    lat_valid |-> (cnt[CNT_MATCH] != '0))
    else $error("latency valid with zero matches");

  // The shared divider never runs with a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIV_MEAN || state == B_DIV_VAR) |-> (divisor != '0))
    else $error("divider started with zero divisor");

  // Min and max are ordered once a match exists
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (state == B_OUT && cnt[CNT_MATCH] != '0) |-> (lat_min <= lat_max))
    else $error("latency min above max");

  // A result only appears from the output state
  a_out_from_state: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == B_OUT))
    else $error("result raised outside output state");
`endif

endmodule

[rtl/start_stop_latency_monitor_top.sv]
// Top level of the start/stop latency monitor.
//
//  channel   dir   handshake          contents
//  in_ch     in    valid/ready        cmd, event_id, deadline_ns, event_kind
//  out_ch    out   valid/ready        counters, latency now/min/max, mean, sdev
//  cfg       in    cfg_we (no ready)  cfg_idx selects register, cfg_data value
//
// Clear, ignored, start, unpaired and mismatched stop transactions pass from the
// execute state to the output state; an order failure passes the latency state
// and the first match the statistics state too. Later matches run the shared serial
// divider (64 steps, used twice), the shift-add multiplier (57) and root (32).
// Synchronous reset clears all statistics; no clearing pass.
// A two-entry queue parts the front end from the back end, and a result register
// holds the finished snapshot while the consumer stalls.
module start_stop_latency_monitor_top import ssl_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  ssl_in_if.sink                in_ch,
  ssl_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  logic f_valid;
  logic f_ready;
  op_t  f_op;
  logic q_valid;
  logic q_ready;
  op_t  q_op;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode      <= 3'd0;
      cfg.window    <= 16'd20;
      cfg.stop_off  <= '0;
      cfg.start_off <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_COMPARE_MODE: cfg.mode      <= cfg_data[2:0];
        CFG_MATCH_WINDOW: cfg.window    <= cfg_data[15:0];
        CFG_STOP_OFFSET:  cfg.stop_off  <= cfg_data;
        CFG_START_OFFSET: cfg.start_off <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  ssl_front u_front (
    .in_ch    (in_ch),
    .mode     (cfg.mode),
    .op_valid (f_valid),
    .op_grant (f_ready),
    .op       (f_op)
  );

  ssl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_op),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_op)
  );

  ssl_back #(
    .FRACTION_BITS (FRACTION_BITS),
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .op_valid (q_valid),
    .op_grant (q_ready),
    .op_in    (q_op),
    .out_ch   (out_ch)
  );

endmodule

[test/tb_top.sv]
// Testbench for the start/stop latency monitor: random and directed events checked against a predictor.
module tb_top;
  import ssl_pkg::*;

  typedef struct {
    bit        cmd;
    bit [63:0] id;
    bit [63:0] dl;
    bit [1:0]  kind;
  } lat_event_t;

  typedef struct {
    bit [31:0]        cnt [6];
    bit signed [47:0] lat_now;
    bit               lat_valid;
    bit signed [47:0] lat_min;
    bit signed [47:0] lat_max;
    bit signed [55:0] mean;
    bit [54:0]        sdev;
  } snapshot_t;

  localparam longint LAT_HI  = 64'sh00007fffffffffff;
  localparam longint LAT_LO  = -LAT_HI - 1;
  localparam longint MEAN_HI = 64'sh007fffffffffffff;
  localparam longint MEAN_LO = -MEAN_HI - 1;
  localparam longint CLAMP62 = 64'sh4000000000000000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  ssl_in_if  in_ch ();
  ssl_out_if out_ch ();

  start_stop_latency_monitor_top DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // Predictor copy of configuration and state
  bit [2:0]  m_mode;
  bit [15:0] m_window;
  bit [31:0] m_stop_off;
  longint    m_start_off;
  bit        m_pend;
  bit [63:0] m_start_time;
  bit [11:0] m_start_evno;
  bit [31:0] m_cnt [6];
  longint    m_last_lat;
  bit        m_last_valid;
  longint    m_min;
  longint    m_max;
  longint    m_mean;
  bit [63:0] m_sqsum;
  bit [63:0] m_sdev;

  lat_event_t pending_events [$];
  snapshot_t  expected_snapshots [$];
  lat_event_t drv_ev;
  bit         in_taken;
  int         send_pct;
  int         recv_pct;
  int         errors;
  int         snapshots_seen;
  int         hold_cnt;
  bit         hold_done;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic bit [63:0] magnitude(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic bit [63:0] int_root(bit [63:0] v);
    bit [63:0] r = 0;
    bit [63:0] b = 64'h4000000000000000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void bump(int k);
    if (m_cnt[k] != 32'hffffffff) m_cnt[k]++;
  endfunction

  function automatic void clear_stats();
    foreach (m_cnt[k]) m_cnt[k] = 0;
    m_last_lat = 0;
    m_last_valid = 0;
    m_min = LAT_HI;
    m_max = LAT_LO;
    m_mean = 0;
    m_sqsum = 0;
    m_sdev = 0;
  endfunction

  // Welford update of mean and squared deviation sum
  function automatic void add_latency(longint lat);
    bit [63:0]  n = {32'b0, m_cnt[CNT_MATCH]};
    longint     x = clamp(lat * 256, MEAN_LO, MEAN_HI);
    longint     d1;
    longint     mnew;
    bit [127:0] p;
    bit [63:0]  p64;
    bit [64:0]  s;
    if (n <= 1) begin
      m_mean = x;
      m_sqsum = 0;
      m_sdev = 0;
      return;
    end
    d1 = x - m_mean;
    mnew = m_mean + d1 / longint'(n);
    p = {64'b0, magnitude(d1)} * {64'b0, magnitude(x - mnew)};
    p64 = (p[127:64] != 0) ? 64'hffffffffffffffff : p[63:0];
    s = {1'b0, m_sqsum} + {1'b0, p64};
    m_sqsum = s[64] ? 64'hffffffffffffffff : s[63:0];
    m_mean = mnew;
    m_sdev = int_root(m_sqsum / (n - 1));
  endfunction

  function automatic void timing_event(bit [63:0] id, bit [63:0] dl, bit [1:0] kind);
    bit [3:0]  fmt = id[63:60];
    bit [11:0] evno = id[47:36];
    longint    diff;
    longint    lat;
    if (fmt != 4'h1 || kind > KIND_STOP) return;
    if (m_mode == MODE_NO_TIME && evno >= EVNO_EXCL_LO && evno <= EVNO_EXCL_HI) return;
    if (kind == KIND_START) begin
      bump(CNT_START);
      m_pend = 1;
      m_start_time = dl;
      m_start_evno = evno;
      m_last_valid = 0;
      return;
    end
    bump(CNT_STOP);
    if (!m_pend) begin
      bump(CNT_NOSTART);
      return;
    end
    if (evno != m_start_evno && m_mode != MODE_NO_EVNO) begin
      bump(CNT_MISMATCH);
      return;
    end
    m_pend = 0;
    diff = longint'(dl - {32'b0, m_stop_off} - m_start_time);
    if (diff < -(longint'(m_window) * 1000)) begin
      bump(CNT_ORDER);
      return;
    end
    diff = clamp(diff, -CLAMP62, CLAMP62);
    if (m_mode == MODE_NO_EVNO) diff = diff + m_start_off;
    lat = clamp(diff, LAT_LO, LAT_HI);
    bump(CNT_MATCH);
    m_last_lat = lat;
    m_last_valid = 1;
    if (lat < m_min) m_min = lat;
    if (lat > m_max) m_max = lat;
    add_latency(lat);
  endfunction

  function automatic snapshot_t predict_snapshot(lat_event_t ev);
    snapshot_t s;
    if (ev.cmd == CMD_CLEAR) clear_stats();
    else timing_event(ev.id, ev.dl, ev.kind);
    foreach (m_cnt[k]) s.cnt[k] = m_cnt[k];
    s.lat_now = m_last_lat[47:0];
    s.lat_valid = m_last_valid;
    s.lat_min = m_min[47:0];
    s.lat_max = m_max[47:0];
    s.mean = m_mean[55:0];
    s.sdev = m_sdev[54:0];
    return s;
  endfunction

  task automatic check_field(string name, bit [63:0] exp_v, bit [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Clock
  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Input driver: offers queued events, idles at random
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_events.size() > 0 && $urandom_range(0, 99) >= send_pct) begin
        drv_ev = pending_events.pop_front();
        in_ch.valid       <= 1;
        in_ch.cmd         <= drv_ev.cmd;
        in_ch.event_id    <= drv_ev.id;
        in_ch.deadline_ns <= drv_ev.dl;
        in_ch.event_kind  <= drv_ev.kind;
      end else begin
        in_ch.valid <= 0;
      end
    end
  end

  // Receiver ready, with one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_ch.ready <= 0;
    end else if (!hold_done && snapshots_seen >= 150) begin
      hold_done = 1;
      hold_cnt = 600;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_pct);
    end
  end

  // Accepted input transactions feed the predictor
  always @(posedge clk) begin
    lat_event_t ev;
    in_taken <= !rst && in_ch.valid && in_ch.ready;
    if (!rst && in_ch.valid && in_ch.ready) begin
      ev.cmd = in_ch.cmd;
      ev.id = in_ch.event_id;
      ev.dl = in_ch.deadline_ns;
      ev.kind = in_ch.event_kind;
      expected_snapshots.push_back(predict_snapshot(ev));
    end
  end

  // Result monitor
  always @(posedge clk) begin
    snapshot_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      snapshots_seen++;
      if (expected_snapshots.size() == 0) begin
        $error("result transaction with no expected snapshot");
        errors++;
      end else begin
        e = expected_snapshots.pop_front();
        check_field("starts_seen", e.cnt[CNT_START], out_ch.starts_seen);
        check_field("stops_seen", e.cnt[CNT_STOP], out_ch.stops_seen);
        check_field("matches_res", e.cnt[CNT_MATCH], out_ch.matches_res);
        check_field("fail_no_start", e.cnt[CNT_NOSTART], out_ch.fail_no_start);
        check_field("fail_event_mismatch", e.cnt[CNT_MISMATCH], out_ch.fail_event_mismatch);
        check_field("fail_order", e.cnt[CNT_ORDER], out_ch.fail_order);
        check_field("latency_now", 64'(unsigned'(e.lat_now)), 64'(unsigned'(out_ch.latency_now)));
        check_field("latency_now_valid", 64'(e.lat_valid), 64'(out_ch.latency_now_valid));
        check_field("latency_min", 64'(unsigned'(e.lat_min)), 64'(unsigned'(out_ch.latency_min)));
        check_field("latency_max", 64'(unsigned'(e.lat_max)), 64'(unsigned'(out_ch.latency_max)));
        check_field("latency_mean", 64'(unsigned'(e.mean)), 64'(unsigned'(out_ch.latency_mean)));
        check_field("latency_sdev", 64'(e.sdev), 64'(out_ch.latency_sdev));
      end
    end
  end

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Timing telegram id with the given format and event number, other bits random
  function automatic bit [63:0] make_id(bit [3:0] fmt, bit [11:0] evno);
    bit [63:0] r = rand64();
    return {fmt, r[59:48], evno, r[35:0]};
  endfunction

  task automatic queue_event(bit cmd, bit [63:0] id, bit [63:0] dl, bit [1:0] kind);
    lat_event_t ev;
    ev.cmd = cmd;
    ev.id = id;
    ev.dl = dl;
    ev.kind = kind;
    pending_events.push_back(ev);
  endtask

  task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [31:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_COMPARE_MODE: m_mode = val[2:0];
      CFG_MATCH_WINDOW: m_window = val[15:0];
      CFG_STOP_OFFSET:  m_stop_off = val;
      CFG_START_OFFSET: m_start_off = longint'(signed'(val));
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_events.size() != 0 || in_ch.valid || expected_snapshots.size() != 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Mostly start/stop pairs with random content, the rest noise
  task automatic queue_random(int count);
    int        r;
    bit [11:0] evno;
    bit [63:0] t;
    bit [63:0] gap;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        case ($urandom_range(0, 3))
          0: evno = 12'($urandom);
          1: evno = 12'(EVNO_EXCL_LO + $urandom_range(0, 5));
          default: evno = 12'(12'h100 + $urandom_range(0, 3));
        endcase
        t = rand64();
        case ($urandom_range(0, 9))
          0: gap = rand64();
          1, 2: gap = -64'($urandom_range(0, 70000000));
          3: gap = {32'b0, $urandom};
          default: gap = 64'($urandom_range(0, 200000));
        endcase
        queue_event(0, make_id(4'h1, evno), t, KIND_START);
        if ($urandom_range(0, 9) == 0)
          queue_event(0, make_id(4'h1, 12'($urandom)), t + 5, KIND_STOP);
        queue_event(0, make_id(4'h1, ($urandom_range(0, 9) == 0) ? 12'($urandom) : evno),
                    t + gap, KIND_STOP);
      end else if (r < 75) begin
        queue_event(1, rand64(), rand64(), 2'($urandom));
      end else if (r < 88) begin
        queue_event(0, make_id(4'h1, 12'($urandom)), rand64(), 2'($urandom));
      end else begin
        queue_event(0, rand64(), rand64(), 2'($urandom));
      end
    end
  endtask

  // Stimulus and phases
  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_idx = 0;
    cfg_data = 0;
    in_ch.valid = 0;
    in_ch.cmd = 0;
    in_ch.event_id = 0;
    in_ch.deadline_ns = 0;
    in_ch.event_kind = 0;
    out_ch.ready = 0;
    in_taken = 0;
    errors = 0;
    snapshots_seen = 0;
    hold_cnt = 0;
    hold_done = 0;
    send_pct = 31;
    recv_pct = 57;
    m_mode = 0;
    m_window = 20;
    m_stop_off = 0;
    m_start_off = 0;
    m_pend = 0;
    m_start_time = 0;
    m_start_evno = 0;
    clear_stats();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed, reset settings
    queue_event(1, 64'hffffffffffffffff, 64'hffffffffffffffff, 2'd3);
    queue_event(0, make_id(4'h1, 12'h123), 64'd1000, KIND_START);
    queue_event(0, make_id(4'h1, 12'h123), 64'd5000, KIND_STOP);
    queue_event(0, make_id(4'h1, 12'h123), 64'd6000, KIND_STOP);
    queue_event(0, make_id(4'h1, 12'h123), 64'd100000, KIND_START);
    queue_event(0, make_id(4'h1, 12'h124), 64'd100010, KIND_STOP);
    queue_event(0, make_id(4'h1, 12'h123), 64'd80001, KIND_STOP);
    queue_event(0, make_id(4'h1, 12'h0e0), 64'd300000, KIND_START);
    queue_event(0, make_id(4'h1, 12'h0e0), 64'd279999, KIND_STOP);
    queue_event(0, make_id(4'h1, 12'h123), 64'd0, 2'd2);
    queue_event(0, make_id(4'h1, 12'h123), 64'd0, 2'd3);
    queue_event(0, 64'h0, 64'h0, KIND_START);
    queue_event(0, make_id(4'hf, 12'h123), 64'd7, KIND_START);
    queue_event(0, make_id(4'h1, 12'h000), 64'd0, KIND_START);
    queue_event(0, make_id(4'h1, 12'h000), 64'h7fffffffffffffff, KIND_STOP);
    queue_event(0, 64'h1fffffffffffffff, 64'hffffffffffffffff, KIND_START);
    queue_event(0, 64'h1fffffffffffffff, 64'hffffffffffffffff, KIND_STOP);
    queue_event(0, make_id(4'h1, 12'h055), 64'h8000000000000000, KIND_START);
    queue_event(0, make_id(4'h1, 12'h055), 64'h0, KIND_STOP);
    queue_event(1, 64'h0, 64'h0, KIND_START);
    queue_random(110);
    wait_drained();

    // Exclusion mode, zero window, largest offsets
    write_reg(CFG_COMPARE_MODE, 32'(MODE_NO_TIME));
    write_reg(CFG_MATCH_WINDOW, 32'd0);
    write_reg(CFG_STOP_OFFSET, 32'hffffffff);
    write_reg(CFG_START_OFFSET, 32'h7fffffff);
    queue_event(0, make_id(4'h1, 12'h0e0), 64'd10, KIND_START);
    queue_event(0, make_id(4'h1, 12'h0e4), 64'd10, KIND_START);
    queue_event(0, make_id(4'h1, 12'h0e5), 64'd10, KIND_START);
    queue_event(0, make_id(4'h1, 12'h0e5), 64'h1_0000_0010, KIND_STOP);
    queue_random(130);
    wait_drained();

    // No event number check, start offset added, widest window
    send_pct = 57;
    recv_pct = 31;
    write_reg(CFG_COMPARE_MODE, 32'(MODE_NO_EVNO));
    write_reg(CFG_MATCH_WINDOW, 32'hffff);
    write_reg(CFG_STOP_OFFSET, 32'd0);
    write_reg(CFG_START_OFFSET, 32'h80000000);
    queue_event(0, make_id(4'h1, 12'h001), 64'd500, KIND_START);
    queue_event(0, make_id(4'h1, 12'h002), 64'd400, KIND_STOP);
    queue_event(0, make_id(4'h1, 12'h0e2), 64'd0, KIND_START);
    queue_event(0, make_id(4'h1, 12'h0e3), 64'h4000000000000000, KIND_STOP);
    queue_random(130);
    wait_drained();

    // Other modes, random window and offsets
    send_pct = 0;
    recv_pct = 0;
    write_reg(CFG_COMPARE_MODE, 32'($urandom_range(5, 7)));
    write_reg(CFG_MATCH_WINDOW, $urandom_range(0, 65535));
    write_reg(CFG_STOP_OFFSET, $urandom_range(0, 1000000));
    write_reg(CFG_START_OFFSET, $urandom);
    queue_random(130);
    wait_drained();

    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Run limit
  initial begin
    #60000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[start_stop_latency_monitor_top.f]
rtl/ssl_pkg.sv
rtl/ssl_channels.sv
rtl/ssl_front.sv
rtl/ssl_queue.sv
rtl/ssl_back.sv
rtl/start_stop_latency_monitor_top.sv
test/tb_top.sv
